>>> rtl/core/pott_pkg.sv
// Shared types and codes for the periodic/one-shot timer table.
package pott_pkg;

  localparam int TASK_W   = 8;
  localparam int MSG_W    = 8;
  localparam int PERIOD_W = 16;
  localparam int REMAIN_W = 17;
  localparam int STEP_W   = 10;
  localparam int ELAPSE_W = 32;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

  typedef struct packed {
    logic                func;
    logic [TASK_W-1:0]   task_id;
    logic [MSG_W-1:0]    msg_id;
    logic [PERIOD_W-1:0] period;
    logic                reload;
  } in_item_t;

  typedef struct packed {
    logic                fired;
    logic [TASK_W-1:0]   fired_task;
    logic [MSG_W-1:0]    fired_msg;
    logic                status;
    logic [ELAPSE_W-1:0] elapsed;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [REMAIN_W-1:0] remaining;
    logic [PERIOD_W-1:0] period;
    logic [TASK_W-1:0]   task_id;
    logic [MSG_W-1:0]    msg_id;
    logic                reload;
  } entry_t;

  typedef struct packed {
    logic shift;   // every cell takes its right neighbour's entry
    logic insert;  // first free cell after the shift takes the new entry
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/pott_cell.sv
// One slot of the timer chain: shifts towards the head and takes appended entries.
module pott_cell (
  input  logic                clk,
  input  logic                rst,
  input  pott_pkg::cell_ctrl_t ctrl,
  input  pott_pkg::entry_t    new_entry,
  input  logic                right_valid,
  input  pott_pkg::entry_t    right_entry,
  input  logic                left_sh_valid,
  output logic                valid,
  output pott_pkg::entry_t    entry,
  output logic                sh_valid
);

  pott_pkg::entry_t sh_entry;
  logic             load;

  always_comb begin
    if (ctrl.shift) begin
      sh_valid = right_valid;
      sh_entry = right_entry;
    end else begin
      sh_valid = valid;
      sh_entry = entry;
    end
  end

  // valid cells stay a prefix, so the first free cell is the append point
  assign load = ctrl.insert && !sh_valid && left_sh_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= sh_valid || load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= new_entry;
    end else begin
      entry <= sh_entry;
    end
  end

endmodule

>>> rtl/core/pott_head.sv
// Expiry check and count update for the entry leaving the head of the chain.
module pott_head (
  input  pott_pkg::entry_t                 entry,
  input  logic [pott_pkg::STEP_W-1:0]      step,
  output logic                             fire,
  output logic                             keep,
  output pott_pkg::entry_t                 updated
);

  logic [pott_pkg::REMAIN_W-1:0] step_ext;

  assign step_ext = pott_pkg::REMAIN_W'(step);
  assign fire     = entry.remaining <= step_ext;
  assign keep     = !fire || entry.reload;

  always_comb begin
    updated = entry;
    if (fire) begin
      updated.remaining = pott_pkg::REMAIN_W'(entry.period);
    end else begin
      updated.remaining = entry.remaining - step_ext;
    end
  end

endmodule

>>> rtl/core/periodic_oneshot_timer_table_top.sv
// Timer table top level: command port, chain of timer cells, result register.
//
// An add gives its single result in the cycle after it is accepted. A tick
// walks the chain once, one entry per cycle through the head unit, then ends
// with its final beat in the done state; busy is high from its accepting edge
// until the edge that takes its final result. On an empty table a tick
// answers on the next cycle like an add and busy stays low. Expiries come
// out in table order, one result per cycle at most, each shown for one cycle
// under result_strobe; the final result of every command has last set. The
// step register takes a write only while the block is idle and no command is
// offered. Results cannot be held off, so the receiver must take every strobe.
module periodic_oneshot_timer_table_top #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  pott_pkg::in_item_t                item,
  output logic                              result_strobe,
  output pott_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pott_pkg::STEP_W-1:0]       cfg_data
);

  localparam int CW = $clog2(TIMER_SLOTS + 1);

  pott_pkg::state_t                  state, state_next;
  logic [pott_pkg::STEP_W-1:0]       tick_step;
  logic [pott_pkg::ELAPSE_W-1:0]     elapsed_ms, elapsed_sum;
  logic [CW-1:0]                     count, left;
  logic                              have_pend;
  logic [pott_pkg::TASK_W-1:0]       pend_task;
  logic [pott_pkg::MSG_W-1:0]        pend_msg;
  pott_pkg::result_t                 result_next;
  logic                              strobe_next;

  logic                              accept, add_go, tick_go, full, add_ok;
  logic                              fire, keep;
  pott_pkg::entry_t                  head_upd, add_entry;
  pott_pkg::cell_ctrl_t              ctrl;
  pott_pkg::entry_t                  new_entry;

  pott_pkg::entry_t                  cell_entry [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0]            cell_valid, cell_sh_valid;

  assign busy        = state != pott_pkg::ST_IDLE;
  // hold the step while a command is offered, so a tick never sees two steps
  assign cfg_ready   = !busy && !start;
  assign accept      = start && !busy;
  assign add_go      = accept && item.func == pott_pkg::FUNC_ADD;
  assign tick_go     = accept && item.func == pott_pkg::FUNC_TICK;
  assign full        = count == CW'(TIMER_SLOTS);
  assign add_ok      = add_go && !full;
  assign elapsed_sum = elapsed_ms + pott_pkg::ELAPSE_W'(tick_step);

  assign add_entry.remaining = pott_pkg::REMAIN_W'(item.period);
  assign add_entry.period    = item.period;
  assign add_entry.task_id   = item.task_id;
  assign add_entry.msg_id    = item.msg_id;
  assign add_entry.reload    = item.reload;

  pott_head u_head (
    .entry   (cell_entry[0]),
    .step    (tick_step),
    .fire    (fire),
    .keep    (keep),
    .updated (head_upd)
  );

  always_comb begin
    ctrl.shift  = state == pott_pkg::ST_TICK;
    ctrl.insert = add_ok || (state == pott_pkg::ST_TICK && keep);
    new_entry   = (state == pott_pkg::ST_TICK) ? head_upd : add_entry;
  end

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    logic             right_valid, left_sh_valid;
    pott_pkg::entry_t right_entry;

    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_valid = cell_valid[i+1];
      assign right_entry = cell_entry[i+1];
    end

    if (i == 0) begin : g_first
      assign left_sh_valid = 1'b1;
    end else begin : g_rest
      assign left_sh_valid = cell_sh_valid[i-1];
    end

    pott_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .new_entry     (new_entry),
      .right_valid   (right_valid),
      .right_entry   (right_entry),
      .left_sh_valid (left_sh_valid),
      .valid         (cell_valid[i]),
      .entry         (cell_entry[i]),
      .sh_valid      (cell_sh_valid[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pott_pkg::ST_IDLE: begin
        if (tick_go && count != '0) state_next = pott_pkg::ST_TICK;
      end
      pott_pkg::ST_TICK: begin
        if (left == CW'(1)) state_next = pott_pkg::ST_DONE;
      end
      pott_pkg::ST_DONE: begin
        state_next = pott_pkg::ST_IDLE;
      end
      default: begin
        state_next = pott_pkg::ST_IDLE;
      end
    endcase
  end

  // result beat
  always_comb begin
    result_next            = '0;
    result_next.elapsed    = elapsed_ms;
    result_next.status     = pott_pkg::STATUS_OK;
    strobe_next            = 1'b0;
    case (state)
      pott_pkg::ST_IDLE: begin
        if (add_go) begin
          strobe_next        = 1'b1;
          result_next.status = full ? pott_pkg::STATUS_FULL : pott_pkg::STATUS_OK;
          result_next.last   = 1'b1;
        end else if (tick_go && count == '0) begin
          strobe_next         = 1'b1;
          result_next.elapsed = elapsed_sum;
          result_next.last    = 1'b1;
        end
      end
      pott_pkg::ST_TICK: begin
        // a held expiry is sent once a later one shows it was not the final beat
        if (fire && have_pend) begin
          strobe_next            = 1'b1;
          result_next.fired      = 1'b1;
          result_next.fired_task = pend_task;
          result_next.fired_msg  = pend_msg;
        end
      end
      pott_pkg::ST_DONE: begin
        strobe_next      = 1'b1;
        result_next.last = 1'b1;
        if (have_pend) begin
          result_next.fired      = 1'b1;
          result_next.fired_task = pend_task;
          result_next.fired_msg  = pend_msg;
        end
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pott_pkg::ST_IDLE;
      tick_step     <= pott_pkg::STEP_RESET;
      elapsed_ms    <= '0;
      count         <= '0;
      left          <= '0;
      have_pend     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= strobe_next;
      if (cfg_valid && cfg_ready) begin
        tick_step <= cfg_data;
      end
      if (tick_go) begin
        elapsed_ms <= elapsed_sum;
        left       <= count;
        have_pend  <= 1'b0;
      end
      if (add_ok) begin
        count <= count + CW'(1);
      end
      if (state == pott_pkg::ST_TICK) begin
        left <= left - CW'(1);
        if (!keep) begin
          count <= count - CW'(1);
        end
        if (fire) begin
          have_pend <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (state == pott_pkg::ST_TICK && fire) begin
      pend_task <= cell_entry[0].task_id;
      pend_msg  <= cell_entry[0].msg_id;
    end
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the periodic/one-shot timer table: directed table, then random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pott_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 16;

  typedef struct {
    in_item_t cmd;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  in_item_t            item;
  logic                result_strobe;
  result_t             result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [STEP_W-1:0]   cfg_data;

  // own copy of the timer table
  entry_t              timer_tbl [SLOTS];
  int unsigned         live_count;
  logic [ELAPSE_W-1:0] elapsed_model;
  logic [STEP_W-1:0]   step_model;

  result_t             expected_reports [$];
  stim_row_t           directed_rows [$];

  int mismatches;
  int fired_seen;
  int adds_taken;
  int refused_adds;
  int ticks_taken;
  int cycle_count;

  periodic_oneshot_timer_table_top #(.TIMER_SLOTS(SLOTS)) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_item_t make_cmd(logic f, logic [TASK_W-1:0] tid,
                                        logic [MSG_W-1:0] mid,
                                        logic [PERIOD_W-1:0] per, logic rl);
    in_item_t c;
    c.func    = f;
    c.task_id = tid;
    c.msg_id  = mid;
    c.period  = per;
    c.reload  = rl;
    return c;
  endfunction

  function automatic result_t plain_report(logic st, logic [ELAPSE_W-1:0] el);
    result_t r;
    r.fired      = 1'b0;
    r.fired_task = '0;
    r.fired_msg  = '0;
    r.status     = st;
    r.elapsed    = el;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic void push_row(in_item_t c, bit typed, result_t want);
    stim_row_t row;
    row.cmd   = c;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t    c;
    int unsigned span;
    c.func    = ($urandom_range(0, 99) < 45) ? FUNC_ADD : FUNC_TICK;
    c.task_id = TASK_W'($urandom);
    c.msg_id  = MSG_W'($urandom);
    c.reload  = 1'($urandom);
    // keep most periods within a few ticks so that timers actually expire
    span = 3 * step_model + 2;
    if ($urandom_range(0, 9) < 7) c.period = PERIOD_W'($urandom_range(0, span));
    else c.period = PERIOD_W'($urandom);
    return c;
  endfunction

  // Apply one command to the table copy and collect the reports it causes.
  task automatic advance_timer_table(input in_item_t c, ref result_t outs[$]);
    int unsigned kept;
    bit          stays;
    result_t     r;
    outs = {};
    if (c.func == FUNC_ADD) begin
      if (live_count < SLOTS) begin
        timer_tbl[live_count].remaining = REMAIN_W'(c.period);
        timer_tbl[live_count].period    = c.period;
        timer_tbl[live_count].task_id   = c.task_id;
        timer_tbl[live_count].msg_id    = c.msg_id;
        timer_tbl[live_count].reload    = c.reload;
        live_count++;
        adds_taken++;
        outs.push_back(plain_report(STATUS_OK, elapsed_model));
      end else begin
        refused_adds++;
        outs.push_back(plain_report(STATUS_FULL, elapsed_model));
      end
    end else begin
      ticks_taken++;
      elapsed_model += ELAPSE_W'(step_model);
      kept = 0;
      for (int i = 0; i < live_count; i++) begin
        stays = 1'b1;
        if (timer_tbl[i].remaining <= REMAIN_W'(step_model)) begin
          r.fired      = 1'b1;
          r.fired_task = timer_tbl[i].task_id;
          r.fired_msg  = timer_tbl[i].msg_id;
          r.status     = STATUS_OK;
          r.elapsed    = elapsed_model;
          r.last       = 1'b0;
          outs.push_back(r);
          if (timer_tbl[i].reload) timer_tbl[i].remaining = REMAIN_W'(timer_tbl[i].period);
          else stays = 1'b0;
        end else begin
          timer_tbl[i].remaining -= REMAIN_W'(step_model);
        end
        // close the gap left by a removed one-shot
        if (stays) begin
          timer_tbl[kept] = timer_tbl[i];
          kept++;
        end
      end
      live_count = kept;
      if (outs.size() == 0) begin
        outs.push_back(plain_report(STATUS_OK, elapsed_model));
      end else begin
        r = outs.pop_back();
        r.last = 1'b1;
        outs.push_back(r);
      end
    end
  endtask

  task automatic send_cmd(input in_item_t c, input bit typed, input result_t want);
    result_t outs [$];
    @(negedge clk);
    start <= 1'b1;
    item  <= c;
    do @(posedge clk); while (busy);
    advance_timer_table(c, outs);
    if (typed) expected_reports.push_back(want);
    else foreach (outs[k]) expected_reports.push_back(outs[k]);
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  endtask

  // Hold off until every report is in and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_reports.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    step_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH (%s) at %0t", what, $realtime);
      $display("  expected fired %0d task %02h msg %02h status %0d elapsed %0d last %0d",
               want.fired, want.fired_task, want.fired_msg, want.status, want.elapsed,
               want.last);
      $display("  actual   fired %0d task %02h msg %02h status %0d elapsed %0d last %0d",
               got.fired, got.fired_task, got.fired_msg, got.status, got.elapsed,
               got.last);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe) begin
      if (result.fired === 1'b1) fired_seen++;
      if (expected_reports.size() == 0) begin
        flag_mismatch("unexpected report", '0, result);
      end else begin
        want = expected_reports.pop_front();
        if (result.fired !== want.fired || result.fired_task !== want.fired_task ||
            result.fired_msg !== want.fired_msg || result.status !== want.status ||
            result.elapsed !== want.elapsed || result.last !== want.last)
          flag_mismatch("field differs", want, result);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports outstanding",
               cycle_count, expected_reports.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [STEP_W-1:0] phase_step [PHASES];
    int                phase_idle [PHASES];
    start         = 1'b0;
    item          = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    rst           = 1'b1;
    live_count    = 0;
    elapsed_model = '0;
    step_model    = STEP_RESET;
    mismatches    = 0;
    fired_seen    = 0;
    adds_taken    = 0;
    refused_adds  = 0;
    ticks_taken   = 0;
    cycle_count   = 0;

    // tick on an empty table, then extreme fields and zero periods
    push_row(make_cmd(FUNC_TICK, 8'h00, 8'h00, 16'h0000, 1'b0), 1, plain_report(STATUS_OK, 1));
    push_row(make_cmd(FUNC_ADD, 8'hFF, 8'hFF, 16'hFFFF, 1'b1), 1, plain_report(STATUS_OK, 1));
    push_row(make_cmd(FUNC_ADD, 8'h00, 8'h00, 16'h0000, 1'b0), 1, plain_report(STATUS_OK, 1));
    push_row(make_cmd(FUNC_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b1), 0, '0);
    push_row(make_cmd(FUNC_ADD, 8'hA5, 8'h5A, 16'h0001, 1'b1), 1, plain_report(STATUS_OK, 2));
    push_row(make_cmd(FUNC_ADD, 8'h12, 8'h34, 16'h0000, 1'b1), 1, plain_report(STATUS_OK, 2));
    push_row(make_cmd(FUNC_ADD, 8'h56, 8'h78, 16'h0002, 1'b0), 1, plain_report(STATUS_OK, 2));
    push_row(make_cmd(FUNC_TICK, 8'h00, 8'h00, 16'h0000, 1'b0), 0, '0);
    push_row(make_cmd(FUNC_TICK, 8'h00, 8'h00, 16'h0000, 1'b0), 0, '0);
    push_row(make_cmd(FUNC_TICK, 8'h00, 8'h00, 16'h0000, 1'b0), 0, '0);
    // fill the table, overflow it once, then fire almost every slot in one tick
    for (int k = 0; k < SLOTS - 3; k++)
      push_row(make_cmd(FUNC_ADD, TASK_W'(k + 16), MSG_W'(~k), 16'h0000, 1'(k)), 1,
               plain_report(STATUS_OK, 5));
    push_row(make_cmd(FUNC_ADD, 8'h3C, 8'hC3, 16'h0005, 1'b1), 1, plain_report(STATUS_FULL, 5));
    push_row(make_cmd(FUNC_TICK, 8'h00, 8'h00, 16'h0000, 1'b0), 0, '0);

    phase_step = '{10'd1000, 10'd0, 10'd1023, STEP_W'($urandom_range(1, 1000)),
                   STEP_W'($urandom_range(2, 40)), STEP_RESET};
    phase_idle = '{8, 8, 59, 59, 0, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      sender_gap(8);
      send_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_step(phase_step[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_gap(phase_idle[p]);
        send_cmd(random_cmd(), 0, '0);
        // let the block drain completely once in mid-stream
        if (p == 1 && n == PHASE_ITEMS / 2) settle();
      end
    end

    settle();
    repeat (SLOTS + 4) @(posedge clk);

    $display("Run covered %0d adds (%0d refused as full) and %0d ticks over %0d step settings,",
             adds_taken, refused_adds, ticks_taken, PHASES + 1);
    $display("with %0d expiries reported and %0d mismatches", fired_seen, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
